[src/itd_pkg.sv]
// Shared constants, types and the digit character map for integer_to_base_digits.
`timescale 1ns / 1ps
package itd_pkg;

   localparam int DEFAULT_VALUE_WIDTH = 64;
   localparam int VALUE_FIELD_WIDTH   = 64;
   localparam int RADIX_WIDTH         = 8;
   localparam int REQ_DATA_WIDTH      = VALUE_FIELD_WIDTH + RADIX_WIDTH;
   localparam int CHAR_WIDTH          = 7;
   localparam int RSP_DATA_WIDTH      = 8;
   localparam int DIGIT_WIDTH         = 4;
   localparam int BASE_WIDTH          = 5;
   // quotient bits retired per cycle by the divider
   localparam int DIV_STEP            = 8;

   localparam logic [BASE_WIDTH-1:0] RADIX_MIN = BASE_WIDTH'(2);
   localparam logic [BASE_WIDTH-1:0] RADIX_MAX = BASE_WIDTH'(16);

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 7'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER  = 7'h57;

   typedef struct packed {
      logic load;
      logic div;
      logic push;
      logic rd;
      logic out_load;
      logic out_last;
   } itd_cmd_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_ascii(logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] ext;
      ext = CHAR_WIDTH'(d);
      if (d < DIGIT_WIDTH'(10)) begin
         return CHAR_ZERO + ext;
      end else begin
         return CHAR_LOWER + ext;
      end
   endfunction

   function automatic logic [BASE_WIDTH-1:0] clamp_radix(logic [RADIX_WIDTH-1:0] r);
      if (r < RADIX_WIDTH'(RADIX_MIN)) begin
         return RADIX_MIN;
      end else if (r > RADIX_WIDTH'(RADIX_MAX)) begin
         return RADIX_MAX;
      end else begin
         return BASE_WIDTH'(r);
      end
   endfunction

endpackage

[src/itd_datapath.sv]
// Datapath: radix divider, digit stack memory and result register.
`timescale 1ns / 1ps
module itd_datapath #(
   parameter int VALUE_WIDTH = itd_pkg::DEFAULT_VALUE_WIDTH,
   parameter int AW          = $clog2(VALUE_WIDTH)
) (
   input  logic                               clock,
   input  itd_pkg::itd_cmd_type               cmd,
   input  logic [AW-1:0]                      addr,
   input  logic [itd_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                               quot_zero,
   output logic [itd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                               rsp_tlast
);
   import itd_pkg::*;

   localparam int QW = ((VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;

   logic [QW-1:0]          quot_ff, quot_in;
   logic [DIGIT_WIDTH-1:0] rem_ff, rem_in;
   logic [BASE_WIDTH-1:0]  base_ff;
   logic [DIGIT_WIDTH-1:0] stack_mem [VALUE_WIDTH];
   logic [DIGIT_WIDTH-1:0] rd_data_ff;
   logic [CHAR_WIDTH-1:0]  char_ff;
   logic                   last_ff;

   always_comb begin
      logic [BASE_WIDTH-1:0] trial;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      for (int i = 0; i < DIV_STEP; i++) begin
         trial   = {rem_in, quot_in[QW-1]};
         quot_in = {quot_in[QW-2:0], 1'b0};
         if (trial >= base_ff) begin
            trial      = trial - base_ff;
            quot_in[0] = 1'b1;
         end
         rem_in = trial[DIGIT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         quot_ff <= QW'(req_tdata[VALUE_WIDTH-1:0]);
         base_ff <= clamp_radix(req_tdata[REQ_DATA_WIDTH-1 -: RADIX_WIDTH]);
         rem_ff  <= '0;
      end else if (cmd.div) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end else if (cmd.push) begin
         rem_ff  <= '0;
      end
      if (cmd.push) begin
         stack_mem[addr] <= rem_ff;
      end
      if (cmd.rd) begin
         rd_data_ff <= stack_mem[addr];
      end
      if (cmd.out_load) begin
         char_ff <= digit_ascii(rd_data_ff);
         last_ff <= cmd.out_last;
      end
   end

   assign quot_zero = (quot_ff == '0);
   assign rsp_tdata = {1'b0, char_ff};
   assign rsp_tlast = last_ff;

endmodule

[src/itd_controller.sv]
// Controller: sequences division passes, digit pushes and digit delivery.
`timescale 1ns / 1ps
module itd_controller #(
   parameter int VALUE_WIDTH = itd_pkg::DEFAULT_VALUE_WIDTH,
   parameter int AW          = $clog2(VALUE_WIDTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 quot_zero,
   output itd_pkg::itd_cmd_type cmd,
   output logic [AW-1:0]        addr
);
   import itd_pkg::*;

   localparam int NCHUNK = (VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP;
   localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_PUSH,
      S_RD,
      S_LOAD,
      S_SEND
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] chunk_ff, chunk_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      chunk_in = chunk_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               chunk_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div = 1'b1;
            if (chunk_ff == CW'(NCHUNK - 1)) begin
               chunk_in = '0;
               state_in = S_PUSH;
            end else begin
               chunk_in = chunk_ff + CW'(1);
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            if (quot_zero) begin
               state_in = S_RD;
            end else begin
               cnt_in   = cnt_ff + AW'(1);
               state_in = S_DIV;
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.out_load = 1'b1;
            cmd.out_last = (cnt_ff == '0);
            state_in     = S_SEND;
         end
         S_SEND: begin
            if (rsp_tready) begin
               if (cnt_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in   = cnt_ff - AW'(1);
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         chunk_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         chunk_ff <= chunk_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_SEND);
   assign addr       = cnt_ff;

endmodule

[src/integer_to_base_digits_top.sv]
// Top level of integer_to_base_digits: unsigned value to ASCII digits in base 2..16.
//
//   channel  direction  payload (low bit first)
//   req      in         tdata: value[63:0], radix[71:64]
//   rsp      out        tdata: digit_char[6:0], zero[7]; tlast: last_digit
//
// One item at a time. Per digit the shared radix divider runs its division
// passes over the value and a push stores the remainder; each digit then leaves
// through the digit stack memory port and the result register, plus rsp stall time.
// Reset is synchronous and clears only the controller.
`timescale 1ns / 1ps
module integer_to_base_digits_top #(
   parameter int VALUE_WIDTH = itd_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [itd_pkg::REQ_DATA_WIDTH-1:0] req_tdata,  // value, radix
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [itd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,  // digit_char, zero pad
   output logic                               rsp_tlast
);
   import itd_pkg::*;

   localparam int AW = $clog2(VALUE_WIDTH);

   itd_cmd_type   cmd;
   logic [AW-1:0] addr;
   logic          quot_zero;

   itd_controller #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .AW          (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .quot_zero  (quot_zero),
      .cmd        (cmd),
      .addr       (addr)
   );

   itd_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .AW          (AW)
   ) u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .addr      (addr),
      .req_tdata (req_tdata),
      .quot_zero (quot_zero),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

[src/itd_checker.sv]
// Port-level checks for integer_to_base_digits_top and their bind.
`timescale 1ns / 1ps
module itd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [itd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic                               rsp_tlast
);
   import itd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("req taken while a digit is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req ready right after accept");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >= 8'h30 && rsp_tdata <= 8'h39) ||
                     (rsp_tdata >= 8'h61 && rsp_tdata <= 8'h66))
      else $error("digit character out of range");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("block not idle after last digit");

endmodule

bind integer_to_base_digits_top itd_checker u_itd_checker (.*);

[verif/testbench.sv]
// Self-checking testbench for integer_to_base_digits_top: digit strings against a local predictor.
`timescale 1ns / 1ps
module testbench;
   import itd_pkg::*;

   localparam int VALUE_BITS = DEFAULT_VALUE_WIDTH;
   localparam logic [63:0] VALUE_MASK = ~64'd0 >> (64 - VALUE_BITS);
   localparam int MAX_DIGITS = 64;
   localparam logic [6:0] ASCII_ZERO = 7'h30;
   localparam logic [6:0] ASCII_LOWER_A = 7'h61;
   localparam int REPORT_LIMIT = 10;
   localparam int DRAIN_CYCLES = 1000;
   localparam int HOLD_CYCLES = 3000;

   typedef struct {
      logic [63:0] value;
      logic [7:0]  radix;
      bit          drain_first;
   } conv_item_type;

   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } digit_exp_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;  // value, radix
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;       // digit_char, zero pad
   logic                      rsp_tlast;

   conv_item_type pending_items[$];
   digit_exp_type digits_expected[$];
   conv_item_type cur_item;
   bit            offering = 1'b0;
   bit            send_idle_on = 1'b1;
   bit            rsp_idle_on = 1'b1;
   bit            hold_rsp = 1'b0;
   int            send_gap = 0;
   int            rsp_stall = 0;
   int            items_sent = 0;
   int            digits_checked = 0;
   int            clamped_items = 0;
   int            zero_items = 0;
   int            fail_count = 0;

   integer_to_base_digits_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endtask

   // expected digit string, most significant digit first
   task automatic predict_digits(input logic [63:0] value, input logic [7:0] radix);
      logic [63:0]   rest;
      logic [4:0]    base;
      logic [3:0]    digit;
      logic [6:0]    rev[MAX_DIGITS];
      int            n;
      digit_exp_type e;
      rest = value & VALUE_MASK;
      if (radix < 8'd2) begin
         base = 5'd2;
      end else if (radix > 8'd16) begin
         base = 5'd16;
      end else begin
         base = radix[4:0];
      end
      if (radix < 8'd2 || radix > 8'd16) clamped_items++;
      if (rest == 64'd0) zero_items++;
      n = 0;
      while (n == 0 || (rest != 64'd0 && n < MAX_DIGITS)) begin
         digit = 4'(rest % base);
         rev[n] = (digit < 4'd10) ? ASCII_ZERO + 7'(digit) : ASCII_LOWER_A + 7'(digit - 4'd10);
         rest = rest / base;
         n++;
      end
      for (int k = n - 1; k >= 0; k--) begin
         e.ch = rev[k];
         e.last = (k == 0);
         digits_expected.push_back(e);
      end
   endtask

   function automatic conv_item_type make_item(input logic [63:0] value, input logic [7:0] radix,
                                               input bit drain_first);
      conv_item_type it;
      it.value = value;
      it.radix = radix;
      it.drain_first = drain_first;
      return it;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_digits(cur_item.value, cur_item.radix);
            items_sent++;
            offering = 1'b0;
            if ($urandom_range(0, 29) == 0) send_idle_on = !send_idle_on;
            send_gap = send_idle_on ? $urandom_range(0, 7) : 0;
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_items.size() > 0) begin
               if (!pending_items[0].drain_first || digits_expected.size() == 0) begin
                  cur_item = pending_items.pop_front();
                  offering = 1'b1;
               end
            end
         end
         req_tvalid <= offering;
         req_tdata <= {cur_item.radix, cur_item.value};
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      digit_exp_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (digits_expected.size() == 0) begin
               note_failure($sformatf("unexpected digit %h last %b", rsp_tdata, rsp_tlast));
            end else begin
               e = digits_expected.pop_front();
               if (rsp_tdata[6:0] !== e.ch) begin
                  note_failure($sformatf("digit_char exp %h got %h", e.ch, rsp_tdata[6:0]));
               end
               if (rsp_tdata[7] !== 1'b0) begin
                  note_failure($sformatf("pad bit exp 0 got %b", rsp_tdata[7]));
               end
               if (rsp_tlast !== e.last) begin
                  note_failure($sformatf("last_digit exp %b got %b", e.last, rsp_tlast));
               end
            end
            digits_checked++;
            if ($urandom_range(0, 59) == 0) rsp_idle_on = !rsp_idle_on;
            rsp_stall = rsp_idle_on ? $urandom_range(0, 7) : 0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_tready <= (rsp_stall == 0) && !hold_rsp;
      end
   end

   // long receiver hold-off so the block backs up its input
   initial begin
      while (items_sent < 60) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #20_000_000;
      $display("timeout: %0d items sent, %0d digits pending", items_sent,
               digits_expected.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [63:0] v;
      logic [7:0]  r;
      int          w;
      // directed: every base, zero, extremes, clamped radix codes
      for (int b = 2; b <= 16; b++) begin
         pending_items.push_back(make_item({$urandom, $urandom}, 8'(b), 1'b0));
      end
      pending_items.push_back(make_item(64'd0, 8'd10, 1'b0));
      pending_items.push_back(make_item(64'd0, 8'd0, 1'b0));
      pending_items.push_back(make_item(~64'd0, 8'd2, 1'b0));
      pending_items.push_back(make_item(~64'd0, 8'd16, 1'b0));
      pending_items.push_back(make_item(~64'd0, 8'd10, 1'b0));
      pending_items.push_back(make_item(~64'd0, 8'd1, 1'b0));
      pending_items.push_back(make_item(64'd1, 8'd255, 1'b0));
      pending_items.push_back(make_item(64'd255, 8'd17, 1'b0));
      pending_items.push_back(make_item(64'h8000_0000_0000_0000, 8'd128, 1'b0));
      for (int i = 0; i < 256; i++) begin
         w = $urandom_range(1, 64);
         v = {$urandom, $urandom} & (~64'd0 >> (64 - w));
         if ($urandom_range(0, 9) < 7) begin
            r = 8'($urandom_range(2, 16));
         end else begin
            r = 8'($urandom_range(0, 255));
         end
         pending_items.push_back(make_item(v, r, i == 100 || i == 200));
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || offering || digits_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (digits_expected.size() != 0) begin
         note_failure($sformatf("%0d digits never arrived", digits_expected.size()));
      end

      $display("Converted %0d values into %0d digits (%0d zero values, %0d clamped radixes).",
               items_sent, digits_checked, zero_items, clamped_items);
      $display("Failures: %0d.", fail_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
